/* src/edtp_pkg.sv */
// Shared types, sizes and codes for the earliest-deadline timer pool.
package edtp_pkg;

  // Pool dimensions.
  localparam int NUM_SLOTS     = 16;
  localparam int TIME_BITS     = 48;
  localparam int INTERVAL_BITS = 32;
  localparam int SLOT_IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Fixed field widths of the channels.
  localparam int OP_BITS       = 2;
  localparam int SLOT_BITS     = 4;
  localparam int DEADLINE_BITS = 48;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Operation codes on the input channel.
  localparam logic [OP_BITS-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [OP_BITS-1:0]       operation;
    logic [SLOT_BITS-1:0]     slot;
    logic [DEADLINE_BITS-1:0] deadline;
    logic [INTERVAL_BITS-1:0] reload_interval;
    logic                     one_shot;
  } in_t;

  // Output transaction, one per firing.
  typedef struct packed {
    logic [SLOT_BITS-1:0] fired_slot;
    logic                 still_armed;
    logic                 last_of_tick;
  } out_t;

  // Classified command kinds held in the queue.
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ADD,
    CMD_REMOVE
  } cmd_kind_e;

  // Classified command.
  typedef struct packed {
    cmd_kind_e                kind;
    logic [SLOT_IDX_W-1:0]    slot;
    logic [TIME_BITS-1:0]     deadline;
    logic [INTERVAL_BITS-1:0] interval;
    logic                     single;
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/earliest_deadline_timer_pool_unit.sv */
// Top level of the earliest-deadline timer pool: front end, command queue and timer engine.
//
// Usage: input transactions on in_valid_i/in_ready_o carry an operation (tick, add,
// remove), a slot and the arming values. Output transactions on out_valid_o/out_ready_i
// report one firing each: the slot, whether it stays armed, and a last-of-tick mark.
// A tick with no due slot produces no output transaction.
// The front end accepts a transaction whenever the four-entry command queue has room,
// so the input side keeps moving while the engine works or the output stalls.
// Add and remove are done by the engine as it pops them. A tick first advances time and
// then captures the due set; each firing then takes a scan over all 16 slots for the
// earliest deadline, then a step that reports it and updates the slot.
// If the receiver stalls, the engine holds the pending firing and the queue fills;
// in_ready_o drops only when the queue is full.
// Reset clears the time count, every armed mark, the queue and the output valid flag;
// the pool accepts transactions in the first cycle after reset.
module earliest_deadline_timer_pool_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  edtp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output edtp_pkg::out_t out_data_o
);
  import edtp_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    push;
  logic    pop;

  // Classification of incoming transactions.
  edtp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Decoupling queue.
  edtp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .stat_o      (q_stat)
  );

  // Timer engine.
  edtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* src/edtp_front.sv */
// Front end: accepts input transactions and classifies them into queue commands.
module edtp_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  edtp_pkg::in_t    in_data_i,
  input  edtp_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output edtp_pkg::cmd_t   cmd_o
);
  import edtp_pkg::*;

  logic slot_ok;
  logic keep;

  // The front stalls only when the queue is full.
  assign in_ready_o = !q_stat_i.full;

  // Slots beyond the pool are ignored by add and remove.
  assign slot_ok = 32'(in_data_i.slot) < NUM_SLOTS;

  // Decode the operation; unknown codes and out-of-range slots are dropped.
  always_comb begin
    keep           = 1'b0;
    cmd_o.kind     = CMD_TICK;
    cmd_o.slot     = SLOT_IDX_W'(in_data_i.slot);
    cmd_o.deadline = TIME_BITS'(in_data_i.deadline);
    cmd_o.interval = in_data_i.reload_interval;
    cmd_o.single   = in_data_i.one_shot;
    case (in_data_i.operation)
      OP_TICK: begin
        keep       = 1'b1;
        cmd_o.kind = CMD_TICK;
      end
      OP_ADD: begin
        keep       = slot_ok;
        cmd_o.kind = CMD_ADD;
      end
      OP_REMOVE: begin
        keep       = slot_ok;
        cmd_o.kind = CMD_REMOVE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && in_ready_o && keep;

endmodule

/* src/edtp_queue.sv */
// Short command queue between the front end and the timer engine.
module edtp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  edtp_pkg::cmd_t    push_data_i,
  input  logic              pop_i,
  output edtp_pkg::cmd_t    pop_data_o,
  output edtp_pkg::q_stat_t stat_o
);
  import edtp_pkg::*;

  cmd_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign stat_o.full  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign stat_o.empty = count_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/edtp_back.sv */
// Timer engine: slot state, time count, due detection and serial earliest-deadline selection.
module edtp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  edtp_pkg::q_stat_t q_stat_i,
  input  edtp_pkg::cmd_t    cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output edtp_pkg::out_t    out_data_o
);
  import edtp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DUE  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIRE = 2'd3;
  localparam int SUM_W = ((TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS) + 1;
  localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(NUM_SLOTS - 1);

  logic [1:0]               state_q, state_d;
  logic [TIME_BITS-1:0]     now_q, now_d;
  logic [NUM_SLOTS-1:0]     armed_q, armed_d;
  logic [NUM_SLOTS-1:0]     due_q, due_d;
  logic [TIME_BITS-1:0]     deadline_q [NUM_SLOTS];
  logic [INTERVAL_BITS-1:0] interval_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]     single_q;
  logic [SLOT_IDX_W-1:0]    idx_q, idx_d;
  logic [SLOT_IDX_W-1:0]    best_q, best_d;
  logic [TIME_BITS-1:0]     best_dl_q, best_dl_d;
  logic                     found_q, found_d;
  logic                     out_valid_q, out_valid_d;
  out_t                     out_q, out_d;
  logic                     wr_add;
  logic                     wr_reload;
  logic                     fire;
  logic [NUM_SLOTS-1:0]     due_now;
  logic [NUM_SLOTS-1:0]     remaining;
  logic [SUM_W-1:0]         reload_sum;
  logic [TIME_BITS-1:0]     reload_dl;

  // Every armed slot whose deadline has been reached by the current time.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      due_now[i] = armed_q[i] && (deadline_q[i] <= now_q);
    end
  end

  // Due set left over once the selected slot has fired.
  assign remaining = due_q & ~(NUM_SLOTS'(1) << best_q);

  // Periodic reload, saturating at the top of the time range.
  assign reload_sum = SUM_W'(best_dl_q) + SUM_W'(interval_q[best_q]);
  assign reload_dl  = ((reload_sum >> TIME_BITS) != '0) ? '1 : reload_sum[TIME_BITS-1:0];

  // Sequencer: execute one command, or run a tick through its firings.
  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    armed_d     = armed_q;
    due_d       = due_q;
    idx_d       = idx_q;
    best_d      = best_q;
    best_dl_d   = best_dl_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    wr_add      = 1'b0;
    wr_reload   = 1'b0;
    fire        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_TICK: begin
              now_d   = now_q + 1'b1;
              state_d = ST_DUE;
            end
            CMD_ADD: begin
              armed_d[cmd_i.slot] = 1'b1;
              wr_add              = 1'b1;
            end
            CMD_REMOVE: begin
              armed_d[cmd_i.slot] = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUE: begin
        // The due set is frozen here, from the state at the tick.
        due_d   = due_now;
        idx_d   = '0;
        found_d = 1'b0;
        state_d = (due_now != '0) ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        // Strict compare in ascending order keeps ties on the lower slot.
        if (due_q[idx_q] && (!found_q || (deadline_q[idx_q] < best_dl_q))) begin
          best_d    = idx_q;
          best_dl_d = deadline_q[idx_q];
          found_d   = 1'b1;
        end
        if (idx_q == LAST_IDX) begin
          state_d = ST_FIRE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FIRE: begin
        // At most one firing per slot per tick.
        if (!out_valid_q || out_ready_i) begin
          fire                 = 1'b1;
          out_valid_d          = 1'b1;
          out_d.fired_slot     = SLOT_BITS'(best_q);
          out_d.still_armed    = !single_q[best_q];
          out_d.last_of_tick   = remaining == '0;
          due_d                = remaining;
          idx_d                = '0;
          found_d              = 1'b0;
          if (single_q[best_q]) begin
            armed_d[best_q] = 1'b0;
          end else begin
            wr_reload = 1'b1;
          end
          state_d = (remaining == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      armed_q     <= '0;
      due_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      armed_q     <= armed_d;
      due_q       <= due_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers and slot storage.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    best_q    <= best_d;
    best_dl_q <= best_dl_d;
    out_q     <= out_d;
    if (wr_add) begin
      deadline_q[cmd_i.slot] <= cmd_i.deadline;
      interval_q[cmd_i.slot] <= cmd_i.interval;
      single_q[cmd_i.slot]   <= cmd_i.single;
    end else if (wr_reload) begin
      deadline_q[best_q] <= reload_dl;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // A firing always has a selected slot behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRE) |-> found_q)
    else $error("fire state reached without a selected slot");

  // A scan only runs while slots remain due.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (due_q != '0))
    else $error("scan running with an empty due set");

  // During a tick every due slot is still armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) || (state_q == ST_FIRE)) |-> ((due_q & ~armed_q) == '0))
    else $error("disarmed slot still marked due");

  // A slot fires at most once per tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> !due_q[$past(best_q)])
    else $error("fired slot still marked due");
`endif

endmodule
